### hw/rtl/assert_macros.svh
// assertion macros for the soil moisture filter rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif

`endif

### hw/rtl/smi_pkg.sv
// shared types, constants and coefficient table for the soil moisture filter
// no dependencies
`default_nettype none

package smi_pkg;

    localparam int HistFracBitsDef = 24;
    localparam int AdcW            = 10;
    localparam int OutW            = 25;
    localparam int HistIntW        = 10;
    localparam int HistDepth       = 4;
    localparam int PtrW            = 2;
    localparam int NumTaps         = 9;
    localparam int TapW            = 4;
    localparam int CoefW           = 36;
    localparam int CoefHalfW       = 21;
    localparam int HalfShift       = 16;
    localparam int GuardW          = 4;
    localparam int MacIssues       = 2 * NumTaps;
    localparam int MacCntW         = 5;
    localparam int PctNumW         = 17;
    localparam int RemW            = 10;
    localparam int FoldTerms       = 5;
    localparam int FoldRemW        = 13;
    localparam int CorrW           = 3;
    localparam int OutWideW        = HistIntW + 17;

    localparam logic [RemW:0]    DivConst = 11'd1023;
    localparam logic [AdcW-1:0]  AdcFull  = 10'd1023;
    localparam logic [6:0]       PctScale = 7'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FILL,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic            valid;
        logic [TapW-1:0] tap;
        logic            half;
    } mac_issue_t;

    // tap 0 is the new sample, 1..4 past inputs, 5..8 past outputs (feedback sign folded in)
    function automatic logic signed [CoefW-1:0] coef_of(input logic [TapW-1:0] tap);
        logic signed [CoefW-1:0] c;
        case (tap)
            4'd0:    c = 36'sd57096;
            4'd1:    c = 36'sd228385;
            4'd2:    c = 36'sd342577;
            4'd3:    c = 36'sd228385;
            4'd4:    c = 36'sd57096;
            4'd5:    c = 36'sd15769956018;
            4'd6:    c = -36'sd21766887341;
            4'd7:    c = 36'sd13382976038;
            4'd8:    c = -36'sd3091991311;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/soil_moisture_iir_lowpass.sv
// soil moisture iir low-pass: top level with sequencer and output register
// uses smi_pkg, smi_div, smi_hist_mem, smi_mac and assert_macros.svh
//
// usage:
//   input channel in_valid/in_ready carries one word: adc_sample and preload.
//   output channel out_valid/out_ready carries filtered_percent, signed Q8.16.
//   every accepted word gives exactly one result word.
//   the time from accept to out_valid does not depend on the history fraction
//   width; a set preload adds a fill phase (one write per history entry). the
//   conversion divider runs first, then the single multiplier (nine taps, two
//   coefficient halves).
//   in_ready is high only between items, so one item is in flight; a new word
//   can be taken in the cycle after the previous result is loaded.
//   the result sits in an output register; while the receiver stalls, the next
//   word is still accepted and processed, and the block then waits with the
//   finished result until the register frees up.
//   reset clears the sequencer, the output valid flag and the history valid
//   bits, so all eight history taps read as zero.
`default_nettype none
`include "assert_macros.svh"

module soil_moisture_iir_lowpass
    import smi_pkg::*;
#(
    parameter int HISTORY_FRAC_BITS = HistFracBitsDef
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [AdcW-1:0]        adc_sample,
    input  wire logic                   preload,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [OutW-1:0]      filtered_percent
);

    localparam int HW = HistIntW + HISTORY_FRAC_BITS;
    localparam logic [MacCntW-1:0] MacLast   = MacCntW'(MacIssues - 1);
    localparam logic [MacCntW-1:0] FillLast  = MacCntW'(HistDepth - 1);
    localparam logic [MacCntW-1:0] DrainLast = MacCntW'(1);

    state_t                  state_reg;
    state_t                  state_next;
    logic [MacCntW-1:0]      cnt_reg;
    logic [MacCntW-1:0]      cnt_next;
    logic [PtrW-1:0]         ptr_reg;
    logic [PtrW-1:0]         ptr_next;
    logic                    pre_reg;
    logic                    pre_next;
    logic signed [HW-1:0]    y_reg;
    logic signed [HW-1:0]    y_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [OutW-1:0]  out_data_reg;
    logic signed [OutW-1:0]  out_data_next;

    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [HW-1:0]           x;
    mac_issue_t              issue;
    logic                    mem_we;
    logic [PtrW-1:0]         mem_waddr;
    logic [PtrW-1:0]         mem_raddr;
    logic signed [HW-1:0]    out_wdata;
    logic signed [HW-1:0]    in_hist;
    logic signed [HW-1:0]    out_hist;
    logic signed [HW-1:0]    mac_y;
    logic signed [OutWideW-1:0] o_wide;
    logic signed [OutW-1:0]  o_sat;

    smi_div #(
        .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .adc_sample (adc_sample),
        .busy       (div_busy),
        .done       (div_done),
        .quotient   (x)
    );

    smi_hist_mem #(
        .W (HW)
    ) u_in_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata ($signed(x)),
        .raddr (mem_raddr),
        .rdata (in_hist)
    );

    smi_hist_mem #(
        .W (HW)
    ) u_out_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (out_wdata),
        .raddr (mem_raddr),
        .rdata (out_hist)
    );

    smi_mac #(
        .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .x        (x),
        .in_hist  (in_hist),
        .out_hist (out_hist),
        .y        (mac_y)
    );

    // newest history entry sits at ptr, older ones follow
    assign mem_raddr = ptr_reg + PtrW'(issue.tap - 4'd1);

    generate
        if (HISTORY_FRAC_BITS > 16)
        begin : g_out_round
            localparam logic signed [HW:0] ORnd = (HW+1)'(1) << (HISTORY_FRAC_BITS - 17);
            logic signed [HW:0] ys;
            assign ys     = (HW+1)'(y_reg) + ORnd;
            assign o_wide = ys[HW:HISTORY_FRAC_BITS-16];
        end
        else
        begin : g_out_plain
            assign o_wide = OutWideW'(y_reg);
        end
    endgenerate

    assign o_sat = ((&o_wide[OutWideW-1:OutW-1]) | ~(|o_wide[OutWideW-1:OutW-1]))
                 ? o_wide[OutW-1:0]
                 : {o_wide[OutWideW-1], {(OutW-1){~o_wide[OutWideW-1]}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            pre_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            pre_reg       <= pre_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg        <= y_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        pre_next       = pre_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;
        div_start      = 1'b0;
        issue          = '0;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[PtrW-1:0];
        out_wdata      = $signed(x);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    div_start  = 1'b1;
                    pre_next   = preload;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    cnt_next   = '0;
                    state_next = pre_reg ? ST_FILL : ST_MAC;
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (cnt_reg == FillLast)
                begin
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MAC:
            begin
                issue.valid = 1'b1;
                issue.tap   = cnt_reg[MacCntW-1:1];
                issue.half  = cnt_reg[0];
                if (cnt_reg == MacLast)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == DrainLast)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                y_next     = mac_y;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = ptr_reg - 1'b1;
                    out_wdata      = y_reg;
                    ptr_next       = ptr_reg - 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = o_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign filtered_percent = out_data_reg;

    `ASSERT_RST(a_accept_starts_div, clk, rst_n, (in_valid && in_ready) |=> div_busy, "divider not started after accept")
    `ASSERT_RST(a_div_done_phase, clk, rst_n, div_done |-> (state_reg == ST_DIV), "divider done outside divide phase")
    `ASSERT_RST(a_ptr_moves_on_load, clk, rst_n, !$stable(ptr_reg) |-> ($past(state_reg) == ST_WRITE) && out_valid_reg, "history pointer moved without a result load")
    `ASSERT_RST(a_issue_tap_range, clk, rst_n, issue.valid |-> (issue.tap < TapW'(NumTaps)), "tap index beyond filter length")

endmodule

`default_nettype wire

### hw/rtl/smi_div.sv
// adc to percent conversion: 100*(1023-adc)*2^F rounded, divided by 1023
// folds the dividend in 10-bit digits (1023 = 2^10 - 1), then corrects the
// estimate from its remainder; uses smi_pkg
`default_nettype none

module smi_div
    import smi_pkg::*;
#(
    parameter int HISTORY_FRAC_BITS = HistFracBitsDef
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [AdcW-1:0]                       adc_sample,
    output logic                                       busy,
    output logic                                       done,
    output logic [HistIntW+HISTORY_FRAC_BITS-1:0]      quotient
);

    localparam int HW     = HistIntW + HISTORY_FRAC_BITS;
    localparam int DvdW   = PctNumW + HISTORY_FRAC_BITS;
    localparam int Stages = 3;

    logic [DvdW-1:0]     dvd_reg;
    logic [HW-1:0]       est_reg;
    logic [HW-1:0]       est_next;
    logic [FoldRemW-1:0] rem_reg;
    logic [FoldRemW-1:0] rem_next;
    logic [CorrW-1:0]    corr;
    logic [HW-1:0]       quot_reg;
    logic [Stages-1:0]   stage_reg;
    logic                done_reg;
    logic [PctNumW-1:0]  pct_num;

    assign pct_num = PctNumW'({7'd0, AdcFull - adc_sample}) * PctNumW'(PctScale);

    // estimate never exceeds the true quotient and is short by less than six
    always_comb
    begin
        est_next = '0;
        for (int i = 1; i <= FoldTerms; i++)
        begin
            est_next = est_next + HW'(dvd_reg >> (RemW * i));
        end
    end

    assign rem_next = FoldRemW'(dvd_reg) + FoldRemW'(est_reg)
                    - {est_reg[FoldRemW-RemW-1:0], {RemW{1'b0}}};

    always_comb
    begin
        logic [FoldRemW-1:0] thr;
        corr = '0;
        thr  = FoldRemW'(DivConst);
        for (int k = 0; k < FoldTerms; k++)
        begin
            if (rem_reg >= thr)
            begin
                corr = corr + 1'b1;
            end
            thr = thr + FoldRemW'(DivConst);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= (DvdW'(pct_num) << HISTORY_FRAC_BITS) | DvdW'(9'h1FF);
        end
        if (stage_reg[0])
        begin
            est_reg <= est_next;
        end
        if (stage_reg[1])
        begin
            rem_reg <= rem_next;
        end
        if (stage_reg[2])
        begin
            quot_reg <= est_reg + HW'(corr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[Stages-2:0], start};
            done_reg  <= stage_reg[Stages-1];
        end
    end

    assign busy     = |stage_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

### hw/rtl/smi_hist_mem.sv
// four-entry history memory, one write and one registered read per cycle
// entries read as zero until first written after reset; uses smi_pkg
`default_nettype none

module smi_hist_mem
    import smi_pkg::*;
#(
    parameter int W = HistIntW + HistFracBitsDef
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 we,
    input  wire logic [PtrW-1:0]      waddr,
    input  wire logic signed [W-1:0]  wdata,
    input  wire logic [PtrW-1:0]      raddr,
    output logic signed [W-1:0]       rdata
);

    logic [W-1:0]         hist_mem [HistDepth];
    logic [W-1:0]         rd_reg;
    logic [HistDepth-1:0] valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[waddr] <= wdata;
        end
        rd_reg <= hist_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? $signed(rd_reg) : '0;

endmodule

`default_nettype wire

### hw/rtl/smi_mac.sv
// shared multiply-accumulate over the nine filter taps, coefficients split into 16-bit low
// and 20-bit high parts; rounds the sum to the history format and saturates; uses smi_pkg
`default_nettype none

module smi_mac
    import smi_pkg::*;
#(
    parameter int HISTORY_FRAC_BITS = HistFracBitsDef
)
(
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire mac_issue_t                                  issue,
    input  wire logic [HistIntW+HISTORY_FRAC_BITS-1:0]       x,
    input  wire logic signed [HistIntW+HISTORY_FRAC_BITS-1:0] in_hist,
    input  wire logic signed [HistIntW+HISTORY_FRAC_BITS-1:0] out_hist,
    output logic signed [HistIntW+HISTORY_FRAC_BITS-1:0]     y
);

    localparam int HW = HistIntW + HISTORY_FRAC_BITS;
    localparam int PW = HW + CoefHalfW;
    localparam int AW = PW + GuardW;
    localparam int YW = AW + 1 - HalfShift;

    mac_issue_t              s1_reg;
    logic signed [HW-1:0]    v_sel;
    logic signed [CoefW-1:0] coef;
    logic signed [CoefHalfW-1:0] coef_sel;
    logic signed [PW-1:0]    prod_next;
    logic signed [PW-1:0]    prod_reg;
    logic                    prod_valid_reg;
    logic                    prod_half_reg;
    logic                    prod_first_reg;
    logic signed [AW-1:0]    acc_hi_reg;
    logic signed [AW-1:0]    acc_lo_reg;
    logic signed [AW-1:0]    prod_ext;
    logic signed [AW:0]      sum;
    logic signed [YW-1:0]    yw;
    logic                    fits;

    always_comb
    begin
        if (s1_reg.tap == '0)
        begin
            v_sel = $signed(x);
        end
        else if (s1_reg.tap inside {[4'd1:4'd4]})
        begin
            v_sel = in_hist;
        end
        else
        begin
            v_sel = out_hist;
        end
        coef = coef_of(s1_reg.tap);
        if (s1_reg.half)
        begin
            coef_sel = $signed({coef[CoefW-1], coef[CoefW-1:HalfShift]});
        end
        else
        begin
            coef_sel = $signed({5'd0, coef[HalfShift-1:0]});
        end
        prod_next = v_sel * coef_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg         <= '0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg         <= issue;
            prod_valid_reg <= s1_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        prod_half_reg  <= s1_reg.half;
        prod_first_reg <= (s1_reg.tap == '0);
    end

    assign prod_ext = AW'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg)
        begin
            if (prod_half_reg)
            begin
                acc_hi_reg <= prod_first_reg ? prod_ext : acc_hi_reg + prod_ext;
            end
            else
            begin
                acc_lo_reg <= prod_first_reg ? prod_ext : acc_lo_reg + prod_ext;
            end
        end
    end

    assign sum  = (AW+1)'(acc_hi_reg) + (AW+1)'(acc_lo_reg >>> HalfShift)
                + (AW+1)'(18'sd32768);
    assign yw   = sum[AW:HalfShift];
    assign fits = (&yw[YW-1:HW-1]) | ~(|yw[YW-1:HW-1]);
    assign y    = fits ? yw[HW-1:0] : {yw[YW-1], {(HW-1){~yw[YW-1]}}};

endmodule

`default_nettype wire

### sim/soil_moisture_iir_lowpass_test.sv
// testbench for soil_moisture_iir_lowpass: random and directed soil words, scoreboard check
// depends on smi_pkg and the soil_moisture_iir_lowpass rtl
`timescale 1ns / 100ps

module soil_moisture_iir_lowpass_test;
    import smi_pkg::*;

    localparam int  FRAC       = HistFracBitsDef;
    localparam int  IDLE_PCT   = 13;
    localparam int  RAND_WORDS = 730;
    localparam int  HOLD_AT    = 150;
    localparam int  HOLD_LEN   = 300;
    localparam int  QUIET_LO   = 350;
    localparam int  QUIET_HI   = 500;
    localparam int  TAIL       = 80;
    localparam longint CYCLE_LIMIT = 500000;
    localparam longint HIST_MAX = (longint'(1) << (9 + FRAC)) - 1;
    localparam longint HIST_MIN = -(longint'(1) << (9 + FRAC));
    localparam longint PCT_MAX  = 16777215;
    localparam longint PCT_MIN  = -16777216;

    class moisture_scoreboard;
        longint feed_fwd [5];
        longint feed_back [4];
        longint past_in [4];
        longint past_out [4];
        longint sum_hi;
        longint sum_lo;
        logic signed [OutW-1:0] pending [$];
        int errors;

        function new();
            feed_fwd  = '{57096, 228385, 342577, 228385, 57096};
            feed_back = '{64'sd15769956018, -64'sd21766887341, 64'sd13382976038,
                          -64'sd3091991311};
            past_in   = '{0, 0, 0, 0};
            past_out  = '{0, 0, 0, 0};
            errors    = 0;
        endfunction

        function void tap_mac(longint v, longint c);
            longint c_lo;
            longint c_hi;
            c_lo = c & 65535;
            c_hi = (c - c_lo) / 65536;
            sum_hi += v * c_hi;
            sum_lo += v * c_lo;
        endfunction

        function void note_sample(logic [AdcW-1:0] adc, logic pre);
            longint pct;
            longint y;
            longint o;
            int i;
            pct = longint'(100 * (1023 - int'(adc))) << FRAC;
            pct = (pct + 511) / 1023;
            if (pct > (longint'(100) << FRAC))
                pct = longint'(100) << FRAC;
            if (pct < 0)
                pct = 0;
            if (pre)
            begin
                for (i = 0; i < 4; i++)
                begin
                    past_in[i]  = pct;
                    past_out[i] = pct;
                end
            end
            sum_hi = 0;
            sum_lo = 0;
            tap_mac(pct, feed_fwd[0]);
            for (i = 0; i < 4; i++)
            begin
                tap_mac(past_in[i], feed_fwd[i + 1]);
                tap_mac(past_out[i], feed_back[i]);
            end
            y = (sum_hi + (sum_lo >>> 16) + 32768) >>> 16;
            if (y > HIST_MAX)
                y = HIST_MAX;
            if (y < HIST_MIN)
                y = HIST_MIN;
            for (i = 3; i > 0; i--)
            begin
                past_in[i]  = past_in[i - 1];
                past_out[i] = past_out[i - 1];
            end
            past_in[0]  = pct;
            past_out[0] = y;
            if (FRAC > 16)
                o = (y + (longint'(1) << (FRAC - 17))) >>> (FRAC - 16);
            else
                o = y;
            if (o > PCT_MAX)
                o = PCT_MAX;
            if (o < PCT_MIN)
                o = PCT_MIN;
            pending.push_back(o[OutW-1:0]);
        endfunction

        function void check_result(logic signed [OutW-1:0] got);
            logic signed [OutW-1:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %0d", $time, got);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (got !== want)
                begin
                    $display("%0t: filtered_percent mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [AdcW-1:0]        adc_sample;
    logic                   preload;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [OutW-1:0] filtered_percent;

    moisture_scoreboard sb = new();
    int     words_in;
    int     words_out;
    longint cycles;
    bit     send_quiet;

    soil_moisture_iir_lowpass dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .adc_sample       (adc_sample),
        .preload          (preload),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .filtered_percent (filtered_percent)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // accepted words on both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_sample(adc_sample, preload);
            words_in++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(filtered_percent);
            words_out++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL soil_moisture_iir_lowpass");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, one quiet stretch
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && words_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (words_out >= QUIET_LO && words_out < QUIET_HI)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [AdcW-1:0] adc, input logic pre);
        while (!send_quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= adc;
        preload    <= pre;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random_words();
        int sent;
        int run;
        int mode;
        int level;
        int step;
        int k;
        int v;
        sent = 0;
        while (sent < RAND_WORDS)
        begin
            send_quiet = (sent >= QUIET_LO && sent < QUIET_HI);
            mode  = $urandom_range(9);
            run   = $urandom_range(40, 5);
            level = $urandom_range(1023);
            step  = $urandom_range(20) - 10;
            if (mode == 0)
            begin
                // noise word
                send_word(AdcW'($urandom_range(1023)), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                for (k = 0; k < run && sent < RAND_WORDS; k++)
                begin
                    if (mode <= 3)
                        v = level + $urandom_range(6) - 3;
                    else if (mode <= 6)
                        v = level + k * step;
                    else if (k < run / 2)
                        v = level;
                    else
                        v = 1023 - level;
                    if (v < 0)
                        v = 0;
                    if (v > 1023)
                        v = 1023;
                    send_word(v[AdcW-1:0], (k == 0) && ($urandom_range(99) < 15));
                    sent++;
                end
            end
        end
        send_quiet = 1'b0;
    endtask

    initial
    begin
        int k;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        adc_sample = '0;
        preload    = 1'b0;
        send_quiet = 1'b0;
        words_in   = 0;
        words_out  = 0;
        cycles     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // step response from the cleared taps, then the extremes and preload
        send_word(10'd0, 1'b0);
        send_word(10'd0, 1'b0);
        send_word(10'd1023, 1'b0);
        send_word(10'd1023, 1'b1);
        for (k = 0; k < 5; k++)
            send_word(10'd0, 1'b0);
        send_word(10'd0, 1'b1);
        send_word(10'd0, 1'b0);
        send_word(10'd1023, 1'b0);
        send_word(10'd1023, 1'b0);
        send_word(10'd511, 1'b0);
        send_word(10'd512, 1'b0);
        send_word(10'd1, 1'b0);
        send_word(10'd1022, 1'b0);
        send_word(10'd341, 1'b0);
        send_word(10'd682, 1'b0);
        send_word(10'h155, 1'b1);
        send_word(10'h2AA, 1'b0);
        send_word(10'd512, 1'b1);
        send_word(10'd512, 1'b0);

        send_random_words();
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        if (sb.errors == 0)
            $display("PASS soil_moisture_iir_lowpass");
        else
            $display("FAIL soil_moisture_iir_lowpass");
        $finish;
    end

endmodule
